// File: hdl/epbf_pkg.sv
package epbf_pkg;

    localparam int MAX_BIN     = 200;
    localparam int COUNT_WIDTH = 24;
    localparam int CLASS_COUNT = 4;

    localparam int CLASS_W = 2;
    localparam int BIN_W   = 8;
    localparam int ADDR_W  = CLASS_W + BIN_W;
    localparam int DEPTH   = 1 << ADDR_W;
    localparam int CUM_W   = COUNT_WIDTH + BIN_W;
    localparam int NB_W    = 5;
    localparam int EDGE_W  = 4;
    localparam int PROD_W  = CUM_W + NB_W;

    localparam logic [CLASS_W-1:0] NEUTRINO_CLASS = 2'd3;
    localparam logic [12:0]        ETA_CUT_RAW    = 13'd2560;
    localparam logic [6:0]         ETA_SCALE      = 7'd80;
    localparam logic [NB_W-1:0]    NB_RESET       = 5'd10;
    localparam logic [NB_W-1:0]    NB_MIN         = 5'd2;
    localparam logic [NB_W-1:0]    NB_MAX         = 5'd16;

    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [1:0]  object_class;
        logic [15:0] energy;
        logic [12:0] abs_eta;
    } in_item_t;

    typedef struct packed {
        logic [3:0] edge_number;
        logic [7:0] energy_edge;
        logic [7:0] eta_edge;
        logic       last;
    } out_item_t;

    typedef struct packed {
        logic clr_step;
        logic load_item;
        logic samp_rd;
        logic samp_wr;
        logic scan_start;
        logic scan_step;
        logic out_load;
        logic edge_next;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic scan_last;
        logic pipe_busy;
        logic last_edge;
        logic out_free;
    } status_t;

    function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

endpackage

// File: hdl/epbf_ctrl.sv
module epbf_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    input  logic             s_kind,
    output logic             s_ready,
    input  epbf_pkg::status_t sts,
    output epbf_pkg::cmd_t    cmd
);

    typedef enum logic [7:0] {
        ST_CLEAR   = 8'b00000001,
        ST_IDLE    = 8'b00000010,
        ST_SAMP_RD = 8'b00000100,
        ST_SAMP_WR = 8'b00001000,
        ST_START   = 8'b00010000,
        ST_SCAN    = 8'b00100000,
        ST_DRAIN   = 8'b01000000,
        ST_LOAD    = 8'b10000000
    } state_t;

    state_t state_reg, state_next;

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load_item = 1'b1;
                    state_next = (s_kind == epbf_pkg::KIND_REPORT) ? ST_START : ST_SAMP_RD;
                end
            end
            ST_SAMP_RD: begin
                cmd.samp_rd = 1'b1;
                state_next  = ST_SAMP_WR;
            end
            ST_SAMP_WR: begin
                cmd.samp_wr = 1'b1;
                state_next  = ST_IDLE;
            end
            ST_START: begin
                cmd.scan_start = 1'b1;
                state_next     = ST_SCAN;
            end
            ST_SCAN: begin
                cmd.scan_step = 1'b1;
                if (sts.scan_last) state_next = ST_DRAIN;
            end
            ST_DRAIN: begin
                if (!sts.pipe_busy) state_next = ST_LOAD;
            end
            ST_LOAD: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    if (sts.last_edge) begin
                        state_next = ST_IDLE;
                    end else begin
                        cmd.edge_next = 1'b1;
                        state_next    = ST_START;
                    end
                end
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= ST_CLEAR;
        else          state_reg <= state_next;
    end

endmodule

// File: hdl/epbf_dp.sv
module epbf_dp (
    input  logic                aclk,
    input  logic                aresetn,
    input  epbf_pkg::in_item_t  s_data,
    input  logic                cfg_valid,
    input  logic [4:0]          cfg_data,
    output logic                m_valid,
    input  logic                m_ready,
    output epbf_pkg::out_item_t m_data,
    input  epbf_pkg::cmd_t      cmd,
    output epbf_pkg::status_t   sts
);

    localparam int CW = epbf_pkg::COUNT_WIDTH;

    logic [CW-1:0] emem [epbf_pkg::DEPTH];
    logic [CW-1:0] hmem [epbf_pkg::DEPTH];
    logic [CW-1:0] totals_reg [epbf_pkg::CLASS_COUNT];

    epbf_pkg::in_item_t  item_reg;
    epbf_pkg::out_item_t out_reg;
    logic                out_valid_reg;

    logic [epbf_pkg::NB_W-1:0]   num_bins_reg, nb_reg;
    logic [epbf_pkg::EDGE_W-1:0] edge_reg;
    logic [epbf_pkg::ADDR_W-1:0] clr_cnt_reg;
    logic [epbf_pkg::BIN_W-1:0]  j_reg;
    logic [epbf_pkg::BIN_W-1:0]  tag1_reg, tag2_reg;
    logic                        v1_reg, v2_reg;
    logic [CW-1:0]               rd_e_reg, rd_h_reg;
    logic [epbf_pkg::CUM_W-1:0]  cum_e_reg, cum_h_reg;
    logic [epbf_pkg::PROD_W-1:0] target_reg;
    logic                        found_e_reg, found_h_reg;
    logic [epbf_pkg::BIN_W-1:0]  edge_e_reg, edge_h_reg;

    // bin arithmetic on the stored sample
    logic [16:0] e_sum;
    logic [12:0] ebin;
    logic [19:0] eta_sum;
    logic [9:0]  etabin;
    logic        is_nu, class_ok, e_ok, eta_cut_ok, h_ok, samp_ok;
    logic [epbf_pkg::NB_W-1:0] nb_clamped;
    logic [epbf_pkg::ADDR_W-1:0] raddr_e, raddr_h, waddr_e, waddr_h;
    logic [CW-1:0] wdata_e, wdata_h;
    logic we_e, we_h;
    logic [epbf_pkg::PROD_W-1:0] prod_e, prod_h;

    assign e_sum      = {1'b0, item_reg.energy} + 17'd15;
    assign ebin       = e_sum[16:4];
    assign eta_sum    = 20'(item_reg.abs_eta) * 20'(epbf_pkg::ETA_SCALE) + 20'd1023;
    assign etabin     = eta_sum[19:10];
    assign is_nu      = (item_reg.object_class == epbf_pkg::NEUTRINO_CLASS);
    assign class_ok   = {1'b0, item_reg.object_class} < 3'(epbf_pkg::CLASS_COUNT);
    assign e_ok       = ebin <= 13'(epbf_pkg::MAX_BIN);
    assign eta_cut_ok = is_nu || (item_reg.abs_eta <= epbf_pkg::ETA_CUT_RAW);
    assign samp_ok    = class_ok && e_ok && eta_cut_ok;
    assign h_ok       = !is_nu && (etabin <= 10'(epbf_pkg::MAX_BIN));

    always_comb begin
        if (num_bins_reg < epbf_pkg::NB_MIN)      nb_clamped = epbf_pkg::NB_MIN;
        else if (num_bins_reg > epbf_pkg::NB_MAX) nb_clamped = epbf_pkg::NB_MAX;
        else                                      nb_clamped = num_bins_reg;
    end

    assign raddr_e = cmd.samp_rd ? {item_reg.object_class, ebin[epbf_pkg::BIN_W-1:0]}
                                 : {item_reg.object_class, j_reg};
    assign raddr_h = cmd.samp_rd ? {item_reg.object_class, etabin[epbf_pkg::BIN_W-1:0]}
                                 : {item_reg.object_class, j_reg};

    assign we_e    = cmd.clr_step || (cmd.samp_wr && samp_ok);
    assign we_h    = cmd.clr_step || (cmd.samp_wr && samp_ok && h_ok);
    assign waddr_e = cmd.clr_step ? clr_cnt_reg
                                  : {item_reg.object_class, ebin[epbf_pkg::BIN_W-1:0]};
    assign waddr_h = cmd.clr_step ? clr_cnt_reg
                                  : {item_reg.object_class, etabin[epbf_pkg::BIN_W-1:0]};
    assign wdata_e = cmd.clr_step ? '0 : epbf_pkg::sat_inc(rd_e_reg);
    assign wdata_h = cmd.clr_step ? '0 : epbf_pkg::sat_inc(rd_h_reg);

    always_ff @(posedge aclk) begin
        if (we_e) emem[waddr_e] <= wdata_e;
        if (we_h) hmem[waddr_h] <= wdata_h;
        rd_e_reg <= emem[raddr_e];
        rd_h_reg <= hmem[raddr_h];
    end

    assign prod_e = epbf_pkg::PROD_W'(cum_e_reg) * epbf_pkg::PROD_W'(nb_reg);
    assign prod_h = epbf_pkg::PROD_W'(cum_h_reg) * epbf_pkg::PROD_W'(nb_reg);

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_bins_reg  <= epbf_pkg::NB_RESET;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            for (int c = 0; c < epbf_pkg::CLASS_COUNT; c++) totals_reg[c] <= '0;
        end else begin
            if (cfg_valid) num_bins_reg <= cfg_data;
            if (cmd.clr_step) clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (cmd.samp_wr && samp_ok)
                totals_reg[item_reg.object_class] <=
                    epbf_pkg::sat_inc(totals_reg[item_reg.object_class]);
            v1_reg <= cmd.scan_step;
            v2_reg <= v1_reg;
            if (cmd.out_load)  out_valid_reg <= 1'b1;
            else if (m_ready)  out_valid_reg <= 1'b0;
        end
    end

    // payload and scan registers
    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            item_reg <= s_data;
            nb_reg   <= nb_clamped;
            edge_reg <= 4'd1;
        end else if (cmd.edge_next) begin
            edge_reg <= edge_reg + 1'b1;
        end
        tag1_reg <= j_reg;
        tag2_reg <= tag1_reg;
        if (cmd.scan_start) begin
            j_reg       <= '0;
            cum_e_reg   <= '0;
            cum_h_reg   <= '0;
            found_e_reg <= 1'b0;
            found_h_reg <= 1'b0;
            edge_e_reg  <= '0;
            edge_h_reg  <= '0;
            target_reg  <= epbf_pkg::PROD_W'(edge_reg) *
                           epbf_pkg::PROD_W'(totals_reg[item_reg.object_class]);
        end else begin
            if (cmd.scan_step) j_reg <= j_reg + 1'b1;
            if (v1_reg) begin
                cum_e_reg <= cum_e_reg + epbf_pkg::CUM_W'(rd_e_reg);
                cum_h_reg <= cum_h_reg + epbf_pkg::CUM_W'(rd_h_reg);
            end
            // first bin past the target wins, bin zero never counts
            if (v2_reg && tag2_reg != '0) begin
                if (!found_e_reg && prod_e > target_reg) begin
                    found_e_reg <= 1'b1;
                    edge_e_reg  <= tag2_reg;
                end
                if (!found_h_reg && prod_h > target_reg) begin
                    found_h_reg <= 1'b1;
                    edge_h_reg  <= tag2_reg;
                end
            end
        end
        if (cmd.out_load) begin
            out_reg.edge_number <= edge_reg;
            out_reg.energy_edge <= edge_e_reg;
            out_reg.eta_edge    <= is_nu ? '0 : edge_h_reg;
            out_reg.last        <= sts.last_edge;
        end
    end

    assign sts.clr_last  = &clr_cnt_reg;
    assign sts.scan_last = (j_reg == epbf_pkg::BIN_W'(epbf_pkg::MAX_BIN));
    assign sts.pipe_busy = v1_reg || v2_reg;
    assign sts.last_edge = ({1'b0, edge_reg} == nb_reg - 5'd1);
    assign sts.out_free  = !out_valid_reg || m_ready;

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!out_valid_reg || m_ready))
        else $error("result overwritten before transfer");

    a_start_idle_pipe: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.scan_start |-> !(v1_reg || v2_reg))
        else $error("scan restarted with reads in flight");

    a_edge_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (found_e_reg && !cmd.scan_start) |=> (!found_e_reg || edge_e_reg != '0))
        else $error("energy edge found at bin zero");

endmodule

// File: hdl/equal_population_bin_edge_finder.sv
// Equal-population bin edge finder.
// Input channel s_valid/s_ready/s_data: kind 0 is a sample that is counted
// into its class histograms, kind 1 asks for the edges of one class.
// Result channel m_valid/m_ready/m_data: a report yields num_bins-1 results,
// edge_number 1 upward, last set on the final one. A sample yields nothing.
// Config channel cfg_valid/cfg_ready/cfg_data writes num_bins (always ready).
// Flow: a sample passes through transfer, histogram read and write back.
// A report scans 201 bins per edge through both histogram memories at one
// read a cycle; each edge is a start step, 201 reads, a drain of the reads
// in flight and a load of the result.
// Each result sits in an output register; the next edge is scanned while
// it waits, and the block stalls only when a new result meets a full output
// register. After a report's last edge is loaded the block takes the next
// item even if that result has not been transferred yet.
// Reset: a clearing pass writes zero to all 1024 entries of both histogram
// memories, with s_ready low; num_bins returns to 10 and class totals to zero.
module equal_population_bin_edge_finder (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  epbf_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output epbf_pkg::out_item_t m_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [4:0]          cfg_data
);

    epbf_pkg::cmd_t    cmd;
    epbf_pkg::status_t sts;

    assign cfg_ready = 1'b1;

    epbf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_kind  (s_data.kind),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    epbf_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule
